// ===== hw/rtl/ubct_pkg.sv =====
package ubct_pkg;

  // Depth of the job queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    FuncDecode = 1'b0,
    FuncEncode = 1'b1
  } func_e;

  // One unit of back-end work: a finished decode or a code value to encode
  typedef struct packed {
    logic        enc;
    logic [31:0] value;
    logic [2:0]  count;
    logic        bad;
  } job_t;

  // Length announced by a lead byte; 1 marks a bad lead byte
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if ((b & 8'hE0) == 8'hC0)      len = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
    else if ((b & 8'hFC) == 8'hF8) len = 3'd5;
    else if ((b & 8'hFE) == 8'hFC) len = 3'd6;
    return len;
  endfunction

  // Number of bytes needed to encode a value; 1 also for values past 31 bits
  function automatic logic [2:0] enc_length(input logic [31:0] v);
    logic [2:0] len;
    len = 3'd1;
    if (v <= 32'h0000_007F)      len = 3'd1;
    else if (v <= 32'h0000_07FF) len = 3'd2;
    else if (v <= 32'h0000_FFFF) len = 3'd3;
    else if (v <= 32'h001F_FFFF) len = 3'd4;
    else if (v <= 32'h03FF_FFFF) len = 3'd5;
    else if (v <= 32'h7FFF_FFFF) len = 3'd6;
    return len;
  endfunction

  // Marker bits of a lead byte for a given sequence length
  function automatic logic [7:0] lead_mark(input logic [2:0] n);
    logic [7:0] m;
    case (n)
      3'd2:    m = 8'hC0;
      3'd3:    m = 8'hE0;
      3'd4:    m = 8'hF0;
      3'd5:    m = 8'hF8;
      3'd6:    m = 8'hFC;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Payload bits a lead byte carries for a given sequence length
  function automatic logic [7:0] lead_keep(input logic [2:0] n);
    logic [7:0] k;
    case (n)
      3'd2:    k = 8'h1F;
      3'd3:    k = 8'h0F;
      3'd4:    k = 8'h07;
      3'd5:    k = 8'h03;
      3'd6:    k = 8'h01;
      default: k = 8'h7F;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/ubct_front.sv =====
module ubct_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              func_i,
  input  logic [31:0]       in_value_i,
  output logic              job_push_o,
  output ubct_pkg::job_t    job_o
);

  logic [30:0] acc_q, acc_d;
  logic [2:0]  exp_q, exp_d;
  logic [2:0]  rcv_q, rcv_d;
  logic        inseq_q, inseq_d;

  logic [7:0]  in_byte;
  logic [2:0]  len;
  logic [30:0] acc_next;
  logic [2:0]  rcv_inc;

  assign in_byte  = in_value_i[7:0];
  assign len      = ubct_pkg::lead_length(in_byte);
  assign acc_next = {acc_q[24:0], in_byte[5:0]};
  assign rcv_inc  = rcv_q + 3'd1;

  // Classify the accepted word and advance the decoder
  always_comb begin
    acc_d       = acc_q;
    exp_d       = exp_q;
    rcv_d       = rcv_q;
    inseq_d     = inseq_q;
    job_push_o  = 1'b0;
    job_o.enc   = 1'b0;
    job_o.value = in_value_i;
    job_o.count = 3'd1;
    job_o.bad   = 1'b0;
    if (accept_i) begin
      if (func_i == ubct_pkg::FuncEncode) begin
        // encode drops any partial decode
        inseq_d     = 1'b0;
        rcv_d       = 3'd0;
        job_push_o  = 1'b1;
        job_o.enc   = 1'b1;
        job_o.count = ubct_pkg::enc_length(in_value_i);
      end else if (!inseq_q) begin
        if (!in_byte[7]) begin
          job_push_o  = 1'b1;
          job_o.value = {24'd0, in_byte};
        end else begin
          exp_d   = len;
          acc_d   = (len == 3'd1) ? {25'd0, in_byte[5:0]}
                                  : {23'd0, in_byte & ubct_pkg::lead_keep(len)};
          rcv_d   = 3'd1;
          inseq_d = 1'b1;
        end
      end else if (exp_q == 3'd1) begin
        // bad lead byte: discard this word and flag the lead
        inseq_d     = 1'b0;
        rcv_d       = 3'd0;
        job_push_o  = 1'b1;
        job_o.value = {1'b0, acc_q};
        job_o.count = 3'd2;
        job_o.bad   = 1'b1;
      end else begin
        acc_d = acc_next;
        if (rcv_inc >= exp_q) begin
          inseq_d     = 1'b0;
          rcv_d       = 3'd0;
          job_push_o  = 1'b1;
          job_o.value = {1'b0, acc_next};
          job_o.count = exp_q;
        end else begin
          rcv_d = rcv_inc;
        end
      end
    end
  end

  // Hold decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      exp_q   <= '0;
      rcv_q   <= '0;
      inseq_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      exp_q   <= exp_d;
      rcv_q   <= rcv_d;
      inseq_q <= inseq_d;
    end
  end

endmodule

// ===== hw/rtl/ubct_queue.sv =====
module ubct_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ubct_pkg::job_t    data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output ubct_pkg::job_t    data_o
);

  ubct_pkg::job_t                     mem_q [ubct_pkg::QDepth];
  logic [ubct_pkg::QPtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [ubct_pkg::QCntW-1:0]         cnt_q;
  logic                               do_push, do_pop;

  assign full_o  = (cnt_q == ubct_pkg::QCntW'(ubct_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [ubct_pkg::QPtrW-1:0] ptr_inc(
      input logic [ubct_pkg::QPtrW-1:0] p);
    logic [ubct_pkg::QPtrW-1:0] r;
    if (p == ubct_pkg::QPtrW'(ubct_pkg::QDepth - 1)) r = '0;
    else                                            r = p + 1'b1;
    return r;
  endfunction

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/ubct_back.sv =====
module ubct_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ubct_pkg::job_t    job_i,
  input  logic              job_empty_i,
  output logic              job_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [30:0]       code_point_o,
  output logic [7:0]        out_byte_o,
  output logic [2:0]        byte_count_o,
  output logic              last_o,
  output logic              bad_lead_o
);

  ubct_pkg::job_t cur_q;
  logic           busy_q;
  logic [2:0]     rem_q;
  logic           out_valid_q;

  logic           advance;
  logic           cur_last;
  logic [4:0]     shamt;
  logic [31:0]    chunk;
  logic [7:0]     enc_byte;

  assign advance   = !out_valid_q || pop_i;
  assign cur_last  = !cur_q.enc || (rem_q == 3'd0);
  assign job_pop_o = !job_empty_i && (!busy_q || (advance && cur_last));
  assign empty_o   = !out_valid_q;

  // Pick the six-bit group for the current byte
  assign shamt = 5'(rem_q) * 5'd6;
  assign chunk = cur_q.value >> shamt;

  // Form the current encoded byte
  always_comb begin
    if (cur_q.count == 3'd1) begin
      enc_byte = cur_q.value[7:0];
    end else if (rem_q == cur_q.count - 3'd1) begin
      enc_byte = ubct_pkg::lead_mark(cur_q.count)
               | (chunk[7:0] & ubct_pkg::lead_keep(cur_q.count));
    end else begin
      enc_byte = {2'b10, chunk[5:0]};
    end
  end

  // Step through the current job one word at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= busy_q;
      end
      if (job_pop_o) begin
        busy_q <= 1'b1;
      end else if (advance && busy_q && cur_last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Load job and result payload
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      cur_q <= job_i;
      rem_q <= job_i.count - 3'd1;
    end else if (advance && busy_q) begin
      rem_q <= rem_q - 3'd1;
    end
    if (advance && busy_q) begin
      code_point_o <= cur_q.value[30:0];
      byte_count_o <= cur_q.count;
      last_o       <= cur_last;
      if (cur_q.enc) begin
        out_byte_o <= enc_byte;
        bad_lead_o <= 1'b0;
      end else begin
        out_byte_o <= 8'd0;
        bad_lead_o <= cur_q.bad;
      end
    end
  end

endmodule

// ===== hw/rtl/utf8_byte_codepoint_transcoder.sv =====
// Six-byte UTF-8 transcoder. With func_i 0 each pushed word carries one UTF-8
// byte in its low 8 bits; the word that completes a sequence yields one
// result (the code point, out_byte 0, last 1), other bytes yield none. A bad
// lead byte (continuation form, 0xFE or 0xFF) swallows the next byte and
// yields the lead byte's low six bits with bad_lead set. With func_i 1 the
// word is a code value that yields 1 to 6 results, one encoded byte each,
// the final one marked last; values above 0x7FFFFFFF yield their low byte
// alone. Encoding abandons a partial decode. The back end emits one byte
// per cycle from its current job while the results are popped, so an encode
// occupies the result side until its bytes are out. A two-entry job queue
// lets the front keep taking words while the back end is busy; a result
// passes through the queue, the current-job register and the result registers.
module utf8_byte_codepoint_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic [31:0] in_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [30:0] code_point_o,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  byte_count_o,
  output logic        last_o,
  output logic        bad_lead_o
);

  logic           accept;
  logic           job_push;
  ubct_pkg::job_t job_in;
  logic           q_full;
  logic           q_empty;
  logic           job_pop;
  ubct_pkg::job_t job_out;

  assign full   = q_full;
  assign accept = push && !q_full;

  ubct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .func_i     (func_i),
    .in_value_i (in_value_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  ubct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (job_pop),
    .empty_o (q_empty),
    .data_o  (job_out)
  );

  ubct_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_out),
    .job_empty_i  (q_empty),
    .job_pop_o    (job_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .code_point_o (code_point_o),
    .out_byte_o   (out_byte_o),
    .byte_count_o (byte_count_o),
    .last_o       (last_o),
    .bad_lead_o   (bad_lead_o)
  );

  // A job is only produced for a word the queue has room for
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_push |-> !q_full)
    else $error("job pushed into full queue");

  // Every shown result has a sequence length of 1 to 6
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (byte_count_o != 3'd0) && (byte_count_o <= 3'd6))
    else $error("result with invalid byte count");

  // A flagged decode is a two-byte, final result with no encoded byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && bad_lead_o) |-> (byte_count_o == 3'd2) && last_o && (out_byte_o == 8'd0))
    else $error("bad lead result malformed");

  // The bytes of one encode follow each other without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_o && pop) |=> !empty)
    else $error("gap inside an encoded sequence");

endmodule
